>>> src/grc_pkg.sv
// Shared types and constants of the clipped glyph rasterizer.
// Used by the rasterizer top level; depends on nothing.
package grc_pkg;

  localparam int MASK_BITS            = 16;
  localparam int DEF_MAX_GLYPH_WIDTH  = 16;
  localparam int DEF_MAX_GLYPH_HEIGHT = 16;
  localparam int DEF_FONT_BYTES       = 8192;

  localparam int COORD_W  = 13;
  localparam int ROW_Y_W  = 14;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int SIZE_W   = 5;
  localparam int COLOR_W  = 24;

  localparam logic [COORD_W-1:0] RST_CLIP_X_MIN = 13'd0;
  localparam logic [COORD_W-1:0] RST_CLIP_Y_MIN = 13'd0;
  localparam logic [COORD_W-1:0] RST_CLIP_X_MAX = 13'd4096;
  localparam logic [COORD_W-1:0] RST_CLIP_Y_MAX = 13'd4096;
  localparam logic [COLOR_W-1:0] RST_DRAW_COLOR = 24'hFFFFFF;
  localparam logic [SIZE_W-1:0]  RST_GLYPH_SIZE = 5'd8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CLIP_X_MIN  = 3'd0,
    REG_CLIP_Y_MIN  = 3'd1,
    REG_CLIP_X_MAX  = 3'd2,
    REG_CLIP_Y_MAX  = 3'd3,
    REG_DRAW_COLOR  = 3'd4,
    REG_GLYPH_WIDTH = 3'd5,
    REG_GLYPH_HEIGHT = 3'd6
  } cfg_reg_e;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_DRAW = 1'b1
  } cmd_e;

  // One row write waiting for delivery.
  typedef struct packed {
    logic signed [ROW_Y_W-1:0] row_y;
    logic [MASK_BITS-1:0]      mask;
  } row_t;

endpackage

>>> src/grc_font_ram.sv
// Font store of the glyph rasterizer: one write port, one registered read port.
// Depends on nothing; instantiated by the rasterizer top level.
module grc_font_ram #(
  parameter int Depth = 8192,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [7:0]       wr_data_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [7:0]       rd_data_o
);

  logic [7:0] mem [Depth];
  logic [7:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> src/glyph_rasterizer_clipped_unit.sv
// Top level of the clipped glyph rasterizer: configuration registers, draw sequencer
// and output stage. Depends on grc_pkg and grc_font_ram.
//
//  channel  direction  handshake                 payload
//  cfg      in         cfg_we_i                  cfg_index_i, cfg_wdata_i
//  in       in         in_valid_i / in_stall_o   command_i .. underline_i
//  out      out        out_valid_o / out_stall_i row_y_o .. last_o
//
// A load item writes one font byte. A draw item passes setup states S_MUL and S_BASE, then
// per glyph row S_ROW alone when the row is clipped (vertically, or all columns), or S_ROW,
// S_FETCH and S_EVAL when it is fetched (three font bytes through the single read port of
// the font store, then the mask), plus S_ROW for the end-of-rows check, S_ULINE for the
// underline row and S_FLUSH for the final flush. Output stalls hold the sequencer only
// when a row is ready while a row is held back and the output register is full.
// Reset clears control state and the configuration registers only; the font store holds garbage until loaded.
// FONT_BYTES must be a power of two; store addresses wrap modulo it.
module glyph_rasterizer_clipped_unit #(
  parameter int MAX_GLYPH_WIDTH  = grc_pkg::DEF_MAX_GLYPH_WIDTH,
  parameter int MAX_GLYPH_HEIGHT = grc_pkg::DEF_MAX_GLYPH_HEIGHT,
  parameter int FONT_BYTES       = grc_pkg::DEF_FONT_BYTES
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [grc_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [grc_pkg::CFG_DATA_W-1:0]        cfg_wdata_i,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic                                  command_i,
  input  logic [12:0]                           font_addr_i,
  input  logic [7:0]                            font_byte_i,
  input  logic [7:0]                            char_code_i,
  input  logic signed [grc_pkg::COORD_W-1:0]    pos_x_i,
  input  logic signed [grc_pkg::COORD_W-1:0]    pos_y_i,
  input  logic                                  underline_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [grc_pkg::ROW_Y_W-1:0]    row_y_o,
  output logic signed [grc_pkg::COORD_W-1:0]    row_x_o,
  output logic [grc_pkg::MASK_BITS-1:0]         pixel_mask_o,
  output logic [31:0]                           pixel_word_o,
  output logic                                  last_o
);
  import grc_pkg::*;

  localparam int AddrW = $clog2(FONT_BYTES);
  localparam int LimW  = (MAX_GLYPH_WIDTH < MASK_BITS) ? MAX_GLYPH_WIDTH : MASK_BITS;
  localparam int LimH  = (MAX_GLYPH_HEIGHT < MASK_BITS) ? MAX_GLYPH_HEIGHT : MASK_BITS;

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_BASE, S_ROW, S_FETCH, S_EVAL, S_ULINE, S_FLUSH
  } state_e;

  // Configuration registers.
  logic [COORD_W-1:0] clip_x_min_q, clip_y_min_q, clip_x_max_q, clip_y_max_q;
  logic [COLOR_W-1:0] draw_color_q;
  logic [SIZE_W-1:0]  glyph_width_q, glyph_height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clip_x_min_q   <= RST_CLIP_X_MIN;
      clip_y_min_q   <= RST_CLIP_Y_MIN;
      clip_x_max_q   <= RST_CLIP_X_MAX;
      clip_y_max_q   <= RST_CLIP_Y_MAX;
      draw_color_q   <= RST_DRAW_COLOR;
      glyph_width_q  <= RST_GLYPH_SIZE;
      glyph_height_q <= RST_GLYPH_SIZE;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_CLIP_X_MIN:   clip_x_min_q   <= cfg_wdata_i[COORD_W-1:0];
        REG_CLIP_Y_MIN:   clip_y_min_q   <= cfg_wdata_i[COORD_W-1:0];
        REG_CLIP_X_MAX:   clip_x_max_q   <= cfg_wdata_i[COORD_W-1:0];
        REG_CLIP_Y_MAX:   clip_y_max_q   <= cfg_wdata_i[COORD_W-1:0];
        REG_DRAW_COLOR:   draw_color_q   <= cfg_wdata_i[COLOR_W-1:0];
        REG_GLYPH_WIDTH:  glyph_width_q  <= cfg_wdata_i[SIZE_W-1:0];
        REG_GLYPH_HEIGHT: glyph_height_q <= cfg_wdata_i[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer and output registers.
  state_e                      state_q, state_d;
  logic [7:0]                  code_q, code_d;
  logic signed [COORD_W-1:0]   px_q, px_d, py_q, py_d;
  logic                        uline_q, uline_d;
  logic [SIZE_W-1:0]           w_q, w_d, h_q, h_d;
  logic [8:0]                  wh_q, wh_d;
  logic [15:0]                 base_q, base_d;
  logic [SIZE_W-1:0]           row_q, row_d;
  logic [MASK_BITS-1:0]        colmask_q, colmask_d;
  logic [1:0]                  k_q, k_d;
  logic [23:0]                 window_q, window_d;
  logic                        pend_valid_q, pend_valid_d;
  row_t                        pend_q, pend_d;
  logic                        out_valid_q, out_valid_d;
  logic signed [ROW_Y_W-1:0]   out_y_q, out_y_d;
  logic signed [COORD_W-1:0]   out_x_q, out_x_d;
  logic [MASK_BITS-1:0]        out_mask_q, out_mask_d;
  logic [31:0]                 out_word_q, out_word_d;
  logic                        out_last_q, out_last_d;

  logic                        in_accept;
  logic                        out_free;
  logic                        push_ok;
  logic [SIZE_W-1:0]           w_sat, h_sat;
  logic signed [ROW_Y_W-1:0]   ry;
  logic                        y_in;
  logic signed [14:0]          col_lo, col_hi;
  logic [MASK_BITS-1:0]        colmask_calc;
  logic [23:0]                 win_shift;
  logic [MASK_BITS-1:0]        row_mask;
  logic [31:0]                 word;
  logic [13:0]                 rd_sum;
  logic [AddrW+13:0]           rd_wide;
  logic [AddrW+12:0]           wr_wide;
  logic [AddrW-1:0]            rd_addr;
  logic [7:0]                  rd_data;
  logic                        font_we;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign push_ok    = !pend_valid_q || out_free;

  assign w_sat = (glyph_width_q > SIZE_W'(LimW)) ? SIZE_W'(LimW) : glyph_width_q;
  assign h_sat = (glyph_height_q > SIZE_W'(LimH)) ? SIZE_W'(LimH) : glyph_height_q;

  // Current row; equals the underline row once row_q has reached the glyph height.
  assign ry   = {py_q[COORD_W-1], py_q} + $signed({{(ROW_Y_W-SIZE_W){1'b0}}, row_q});
  assign y_in = ($signed({ry[ROW_Y_W-1], ry}) >= $signed({2'b00, clip_y_min_q})) &&
                ($signed({ry[ROW_Y_W-1], ry}) <  $signed({2'b00, clip_y_max_q}));

  // Column j is visible when j < w_q and clip_x_min - px <= j < clip_x_max - px.
  assign col_lo = $signed({2'b00, clip_x_min_q}) - $signed({{2{px_q[COORD_W-1]}}, px_q});
  assign col_hi = $signed({2'b00, clip_x_max_q}) - $signed({{2{px_q[COORD_W-1]}}, px_q});

  always_comb begin
    for (int j = 0; j < MASK_BITS; j++) begin
      colmask_calc[j] = (SIZE_W'(j) < w_q) &&
                        ($signed(15'(j)) >= col_lo) && ($signed(15'(j)) < col_hi);
    end
  end

  assign win_shift = window_q >> base_q[2:0];
  assign row_mask  = win_shift[MASK_BITS-1:0] & colmask_q;
  assign word      = {draw_color_q[7:0], draw_color_q[15:8], draw_color_q[23:16], 8'h00};

  assign rd_sum  = {1'b0, base_q[15:3]} + {12'b0, k_q};
  assign rd_wide = (AddrW+14)'(rd_sum);
  assign rd_addr = rd_wide[AddrW-1:0];
  assign wr_wide = (AddrW+13)'(font_addr_i);
  assign font_we = in_accept && (cmd_e'(command_i) == CMD_LOAD);

  grc_font_ram #(
    .Depth(FONT_BYTES)
  ) u_font_ram (
    .clk_i    (clk_i),
    .we_i     (font_we),
    .wr_addr_i(wr_wide[AddrW-1:0]),
    .wr_data_i(font_byte_i),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  always_comb begin
    state_d      = state_q;
    code_d       = code_q;
    px_d         = px_q;
    py_d         = py_q;
    uline_d      = uline_q;
    w_d          = w_q;
    h_d          = h_q;
    wh_d         = wh_q;
    base_d       = base_q;
    row_d        = row_q;
    colmask_d    = colmask_q;
    k_d          = k_q;
    window_d     = window_q;
    pend_valid_d = pend_valid_q;
    pend_d       = pend_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_y_d      = out_y_q;
    out_x_d      = out_x_q;
    out_mask_d   = out_mask_q;
    out_word_d   = out_word_q;
    out_last_d   = out_last_q;

    case (state_q)
      S_IDLE: begin
        if (in_accept && (cmd_e'(command_i) == CMD_DRAW)) begin
          code_d  = char_code_i;
          px_d    = pos_x_i;
          py_d    = pos_y_i;
          uline_d = underline_i;
          w_d     = w_sat;
          h_d     = h_sat;
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        wh_d      = 9'(w_q * h_q);
        colmask_d = colmask_calc;
        state_d   = S_BASE;
      end
      S_BASE: begin
        base_d  = 16'(code_q * wh_q);
        row_d   = '0;
        state_d = S_ROW;
      end
      S_ROW: begin
        if (row_q == h_q) begin
          state_d = S_ULINE;
        end else if (y_in && (colmask_q != '0)) begin
          k_d     = '0;
          state_d = S_FETCH;
        end else begin
          row_d  = row_q + 1'b1;
          base_d = base_q + {11'b0, w_q};
        end
      end
      S_FETCH: begin
        // Each byte arrives in the cycle after its address; the first byte lands lowest.
        if (k_q != 2'd0) begin
          window_d = {rd_data, window_q[23:8]};
        end
        k_d = k_q + 1'b1;
        if (k_q == 2'd3) begin
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        if (row_mask == '0 || push_ok) begin
          if (row_mask != '0) begin
            if (pend_valid_q) begin
              out_valid_d = 1'b1;
              out_y_d     = pend_q.row_y;
              out_x_d     = px_q;
              out_mask_d  = pend_q.mask;
              out_word_d  = word;
              out_last_d  = 1'b0;
            end
            pend_valid_d = 1'b1;
            pend_d.row_y = ry;
            pend_d.mask  = row_mask;
          end
          row_d   = row_q + 1'b1;
          base_d  = base_q + {11'b0, w_q};
          state_d = S_ROW;
        end
      end
      S_ULINE: begin
        if (uline_q && (colmask_q != '0) && y_in) begin
          if (push_ok) begin
            if (pend_valid_q) begin
              out_valid_d = 1'b1;
              out_y_d     = pend_q.row_y;
              out_x_d     = px_q;
              out_mask_d  = pend_q.mask;
              out_word_d  = word;
              out_last_d  = 1'b0;
            end
            pend_valid_d = 1'b1;
            pend_d.row_y = ry;
            pend_d.mask  = colmask_q;
            state_d      = S_FLUSH;
          end
        end else begin
          state_d = S_FLUSH;
        end
      end
      S_FLUSH: begin
        // The row still held back is the last one of this character.
        if (!pend_valid_q) begin
          state_d = S_IDLE;
        end else if (out_free) begin
          out_valid_d  = 1'b1;
          out_y_d      = pend_q.row_y;
          out_x_d      = px_q;
          out_mask_d   = pend_q.mask;
          out_word_d   = word;
          out_last_d   = 1'b1;
          pend_valid_d = 1'b0;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    code_q     <= code_d;
    px_q       <= px_d;
    py_q       <= py_d;
    uline_q    <= uline_d;
    w_q        <= w_d;
    h_q        <= h_d;
    wh_q       <= wh_d;
    base_q     <= base_d;
    row_q      <= row_d;
    colmask_q  <= colmask_d;
    k_q        <= k_d;
    window_q   <= window_d;
    pend_q     <= pend_d;
    out_y_q    <= out_y_d;
    out_x_q    <= out_x_d;
    out_mask_q <= out_mask_d;
    out_word_q <= out_word_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o  = out_valid_q;
  assign row_y_o      = out_y_q;
  assign row_x_o      = out_x_q;
  assign pixel_mask_o = out_mask_q;
  assign pixel_word_o = out_word_q;
  assign last_o       = out_last_q;

  // No row is held back once the sequencer is back at rest.
  a_idle_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> !pend_valid_q)
    else $error("pending row left behind in idle");

  // Empty rows are never delivered.
  a_mask_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_mask_q != '0)
    else $error("row write with empty mask");

  // The final row of a character leaves nothing behind it.
  a_last_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FLUSH && pend_valid_q && out_free |=>
      out_valid_q && out_last_q && !pend_valid_q)
    else $error("row pending behind a final row write");

  // A draw item always starts the sequencer.
  a_draw_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && command_i == CMD_DRAW |=> state_q == S_MUL)
    else $error("draw item did not start the sequencer");

endmodule
